// File: rtl/core/lars_pkg.sv
// ----------------------------------------------------------------------------
// lars_pkg: shared constants and types of the ambient reflectance sensor
// Sample width default, channel count and the sequencer control bundle.
// ----------------------------------------------------------------------------
package lars_pkg;

  // default ADC code width
  localparam int LARS_SAMPLE_BITS = 12;

  // reflectance channels per scan
  localparam int LARS_CHANNELS = 4;

  // channels captured lit in the first lit phase (the rest in the second)
  localparam int LARS_LO_CHANNELS = LARS_CHANNELS / 2;

  // per-scan control from the phase sequencer to the channel datapath
  typedef struct packed {
    logic lit_lo;    // capture lit values of channels 0 and 1
    logic lit_hi;    // capture lit values of channels 2 and 3
    logic frame;     // dark scan: form lit minus dark and update levels
    logic emit_one;  // first emitter drive after this scan
    logic emit_two;  // second emitter drive after this scan
  } lars_ctrl_t;

endpackage

// File: rtl/core/lars_if.sv
// ----------------------------------------------------------------------------
// lars_if: valid/ready channels of the ambient reflectance sensor
// Scan channel (battery plus four reflectance codes) and result channel.
// ----------------------------------------------------------------------------
interface lars_in_if import lars_pkg::*; #(
  parameter int SAMPLE_BITS = LARS_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] battery_sample;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic [SAMPLE_BITS-1:0] sample_c;
  logic [SAMPLE_BITS-1:0] sample_d;

  modport source (
    output valid, battery_sample, sample_a, sample_b, sample_c, sample_d,
    input  ready
  );
  modport sink (
    input  valid, battery_sample, sample_a, sample_b, sample_c, sample_d,
    output ready
  );
endinterface

interface lars_out_if import lars_pkg::*; #(
  parameter int SAMPLE_BITS = LARS_SAMPLE_BITS
);
  logic                       valid;
  logic                       ready;
  logic                       emitter_one;
  logic                       emitter_two;
  logic                       frame_done;
  logic [SAMPLE_BITS-1:0]     battery_code;
  logic [SAMPLE_BITS-1:0]     level_a;
  logic [SAMPLE_BITS-1:0]     level_b;
  logic [SAMPLE_BITS-1:0]     level_c;
  logic [SAMPLE_BITS-1:0]     level_d;
  logic signed [SAMPLE_BITS:0] change_a;
  logic signed [SAMPLE_BITS:0] change_b;
  logic signed [SAMPLE_BITS:0] change_c;
  logic signed [SAMPLE_BITS:0] change_d;

  modport source (
    output valid, emitter_one, emitter_two, frame_done, battery_code,
           level_a, level_b, level_c, level_d,
           change_a, change_b, change_c, change_d,
    input  ready
  );
  modport sink (
    input  valid, emitter_one, emitter_two, frame_done, battery_code,
           level_a, level_b, level_c, level_d,
           change_a, change_b, change_c, change_d,
    output ready
  );
endinterface

// File: rtl/core/lars_seq.sv
// ----------------------------------------------------------------------------
// lars_seq: four-phase emitter sequencer
// Steps through the LED phases once per processed scan and decodes control.
// ----------------------------------------------------------------------------
module lars_seq import lars_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  output lars_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LIT1 = 4'b0010,
    PH_LIT2 = 4'b0100,
    PH_DARK = 4'b1000
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  // next phase, wrapping after the dark scan
  always_comb begin
    unique case (phase)
      PH_IDLE: phase_next = PH_LIT1;
      PH_LIT1: phase_next = PH_LIT2;
      PH_LIT2: phase_next = PH_DARK;
      PH_DARK: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  // control decode for the scan being processed
  always_comb begin
    ctrl = '0;
    unique case (phase)
      PH_IDLE: begin
        ctrl.emit_two = 1'b1;
      end
      PH_LIT1: begin
        ctrl.lit_lo   = 1'b1;
        ctrl.emit_one = 1'b1;
      end
      PH_LIT2: begin
        ctrl.lit_hi = 1'b1;
      end
      PH_DARK: begin
        ctrl.frame = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

// File: rtl/core/lars_chan.sv
// ----------------------------------------------------------------------------
// lars_chan: one reflectance channel
// Holds the lit sample, the level and the change; on a dark scan forms
// lit minus dark and takes it as the new level when it is in range.
// ----------------------------------------------------------------------------
module lars_chan import lars_pkg::*; #(
  parameter int SAMPLE_BITS = LARS_SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    lit_we,
  input  logic                    frame,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic [SAMPLE_BITS-1:0]  level_next,
  output logic signed [SAMPLE_BITS:0] change_next
);

  logic [SAMPLE_BITS-1:0]     lit;
  logic [SAMPLE_BITS-1:0]     level;
  logic signed [SAMPLE_BITS:0] change;
  logic [SAMPLE_BITS:0]       diff;
  logic                       in_range;
  logic [SAMPLE_BITS-1:0]     new_level;

  // lit minus dark; accept only 1 .. full scale minus one
  always_comb begin
    diff      = {1'b0, lit} - {1'b0, sample};
    in_range  = !diff[SAMPLE_BITS] && (diff[SAMPLE_BITS-1:0] != '0)
                && (diff[SAMPLE_BITS-1:0] != '1);
    new_level = in_range ? diff[SAMPLE_BITS-1:0] : level;
    if (frame) begin
      level_next  = new_level;
      change_next = signed'({1'b0, level} - {1'b0, new_level});
    end else begin
      level_next  = level;
      change_next = change;
    end
  end

  // lit capture (no reset, always written before a dark scan reads it)
  always_ff @(posedge clk) begin
    if (advance && lit_we) begin
      lit <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      change <= '0;
    end else if (advance) begin
      level  <= level_next;
      change <= change_next;
    end
  end

endmodule

// File: rtl/core/led_ambient_reflect_sensor_core.sv
// ----------------------------------------------------------------------------
// led_ambient_reflect_sensor_core: LED on/off ambient light subtraction
// Four-phase emitter sequence, lit/dark capture and level tracking.
// ----------------------------------------------------------------------------
// Each transfer on scan is one finished ADC scan and yields exactly one
// transfer on result. A scan is captured in an input register, processed by
// the phase sequencer and the four channel slices while it sits there, and
// lands in the result register once that register is free or being taken,
// where its result is offered. With result.ready held high a new scan can be
// taken every cycle; the rate is one scan per clock, set by the single pass
// from input to result register. While a result waits for result.ready the
// input register still takes one more scan and then holds scan.ready low
// until the waiting result is taken.
// Phase 0 drives emitter two, phase 1 emitter one and captures channels 0
// and 1, phase 2 captures channels 2 and 3, and phase 3 is the dark scan
// that updates the levels and raises frame_done.
module led_ambient_reflect_sensor_core import lars_pkg::*; #(
  parameter int SAMPLE_BITS = LARS_SAMPLE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  lars_in_if.sink        scan,
  lars_out_if.source     result
);

  // input register
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_batt;
  logic [SAMPLE_BITS-1:0] s1_smp [LARS_CHANNELS];
  logic                   s1_advance;

  // result register
  logic                        o_valid;
  logic                        o_emit_one;
  logic                        o_emit_two;
  logic                        o_done;
  logic [SAMPLE_BITS-1:0]      o_batt;
  logic [SAMPLE_BITS-1:0]      o_level  [LARS_CHANNELS];
  logic signed [SAMPLE_BITS:0] o_change [LARS_CHANNELS];

  lars_ctrl_t                  ctrl;
  logic [SAMPLE_BITS-1:0]      level_next  [LARS_CHANNELS];
  logic signed [SAMPLE_BITS:0] change_next [LARS_CHANNELS];

  // handshakes
  assign s1_advance = s1_valid && (!o_valid || result.ready);
  assign scan.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_batt   <= scan.battery_sample;
      s1_smp[0] <= scan.sample_a;
      s1_smp[1] <= scan.sample_b;
      s1_smp[2] <= scan.sample_c;
      s1_smp[3] <= scan.sample_d;
    end
  end

  // phase sequencer
  lars_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .ctrl    (ctrl)
  );

  // channel slices
  for (genvar i = 0; i < LARS_CHANNELS; i++) begin : g_chan
    lars_chan #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chan (
      .clk         (clk),
      .rst         (rst),
      .advance     (s1_advance),
      .lit_we      ((i < LARS_LO_CHANNELS) ? ctrl.lit_lo : ctrl.lit_hi),
      .frame       (ctrl.frame),
      .sample      (s1_smp[i]),
      .level_next  (level_next[i]),
      .change_next (change_next[i])
    );
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_advance) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      o_emit_one <= ctrl.emit_one;
      o_emit_two <= ctrl.emit_two;
      o_done     <= ctrl.frame;
      o_batt     <= s1_batt;
      o_level    <= level_next;
      o_change   <= change_next;
    end
  end

  assign result.valid        = o_valid;
  assign result.emitter_one  = o_emit_one;
  assign result.emitter_two  = o_emit_two;
  assign result.frame_done   = o_done;
  assign result.battery_code = o_batt;
  assign result.level_a      = o_level[0];
  assign result.level_b      = o_level[1];
  assign result.level_c      = o_level[2];
  assign result.level_d      = o_level[3];
  assign result.change_a     = o_change[0];
  assign result.change_b     = o_change[1];
  assign result.change_c     = o_change[2];
  assign result.change_d     = o_change[3];

  // a dark scan never leaves an emitter lit
  a_frame_dark: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_done |-> !o_emit_one && !o_emit_two)
    else $error("frame result with an emitter lit");

  // the two emitters are never driven together
  a_emit_excl: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_emit_one && o_emit_two))
    else $error("both emitters lit");

  // a scan held in the input register is not lost while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_batt))
    else $error("input register lost a stalled scan");

  // a processed scan always lands in the result register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> o_valid)
    else $error("processed scan did not reach the result register");

  // the phase after a dark scan drives emitter two
  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    s1_advance && ctrl.frame |=> ctrl.emit_two && !ctrl.frame)
    else $error("phase did not wrap after the dark scan");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of led_ambient_reflect_sensor_core
// Drives whole LED frames of ADC scans through the scan channel. Each result
// transfer is checked against a cycle-free model of the emitter sequence,
// the lit/dark capture and the level tracking. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import lars_pkg::*;

  localparam int SB          = LARS_SAMPLE_BITS;
  localparam int SAMPLE_FULL = (1 << SB) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  // emitter sequence position of the next scan
  typedef enum logic [1:0] {
    PH_EMIT_TWO,
    PH_LIT_LO,
    PH_LIT_HI,
    PH_DARK
  } phase_t;

  typedef logic [LARS_CHANNELS-1:0][SB-1:0] chan_t;

  typedef struct packed {
    logic [SB-1:0] battery;
    chan_t         smp;
  } scan_t;

  typedef struct packed {
    logic                           emit_one;
    logic                           emit_two;
    logic                           frame_done;
    logic [SB-1:0]                  battery;
    chan_t                          level;
    logic [LARS_CHANNELS-1:0][SB:0] change;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lars_in_if  #(.SAMPLE_BITS(SB)) scan ();
  lars_out_if #(.SAMPLE_BITS(SB)) result ();

  led_ambient_reflect_sensor_core #(.SAMPLE_BITS(SB)) DUT (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .result (result)
  );

  always #5 clk = ~clk;

  // model state
  phase_t phase_q = PH_EMIT_TWO;
  chan_t  lit_q   = '0;
  chan_t  level_q = '0;
  logic [LARS_CHANNELS-1:0][SB:0] change_q = '0;

  reading_t pending_readings[$];
  int       fault_cnt    = 0;
  int       cycle_cnt    = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;

  // one scan through the sequencer: capture, subtract, track levels
  function automatic reading_t predict_reading(scan_t s);
    reading_t      r;
    int            diff;
    logic [SB-1:0] prev;
    r         = '0;
    r.battery = s.battery;
    case (phase_q)
      PH_EMIT_TWO: r.emit_two = 1'b1;
      PH_LIT_LO: begin
        for (int ch = 0; ch < LARS_LO_CHANNELS; ch++) lit_q[ch] = s.smp[ch];
        r.emit_one = 1'b1;
      end
      PH_LIT_HI: begin
        for (int ch = LARS_LO_CHANNELS; ch < LARS_CHANNELS; ch++) lit_q[ch] = s.smp[ch];
      end
      PH_DARK: begin
        for (int ch = 0; ch < LARS_CHANNELS; ch++) begin
          diff = int'(lit_q[ch]) - int'(s.smp[ch]);
          prev = level_q[ch];
          // only a difference strictly inside the code range updates the level
          if (diff > 0 && diff < SAMPLE_FULL) level_q[ch] = diff[SB-1:0];
          change_q[ch] = {1'b0, prev} - {1'b0, level_q[ch]};
        end
        r.frame_done = 1'b1;
      end
    endcase
    phase_q  = (phase_q == PH_DARK) ? PH_EMIT_TWO : phase_t'(phase_q + 2'd1);
    r.level  = level_q;
    r.change = change_q;
    return r;
  endfunction

  function automatic string reading_str(reading_t r);
    return $sformatf("led=%b%b done=%b batt=%0d lvl=%0d/%0d/%0d/%0d chg=%0d/%0d/%0d/%0d",
                     r.emit_one, r.emit_two, r.frame_done, r.battery,
                     r.level[0], r.level[1], r.level[2], r.level[3],
                     $signed(r.change[0]), $signed(r.change[1]),
                     $signed(r.change[2]), $signed(r.change[3]));
  endfunction

  function automatic chan_t chans(int a, int b, int c, int d);
    chan_t v;
    v[0] = a[SB-1:0];
    v[1] = b[SB-1:0];
    v[2] = c[SB-1:0];
    v[3] = d[SB-1:0];
    return v;
  endfunction

  function automatic logic [SB-1:0] edge_code();
    case ($urandom_range(3))
      0:       return '0;
      1:       return SB'(1);
      2:       return SB'(SAMPLE_FULL - 1);
      default: return SB'(SAMPLE_FULL);
    endcase
  endfunction

  // mostly uniform codes, now and then a range edge
  function automatic logic [SB-1:0] pick_code();
    if ($urandom_range(7) == 0) return edge_code();
    return SB'($urandom_range(SAMPLE_FULL));
  endfunction

  // lit/dark pair of one channel, biased toward level updates
  function automatic void pick_pair(output logic [SB-1:0] lit, output logic [SB-1:0] dark);
    int unsigned mode;
    int unsigned k;
    mode = $urandom_range(9);
    lit  = SB'($urandom_range(SAMPLE_FULL));
    if (mode < 5) begin
      if (lit == 0) lit = SB'(1);
      k    = $urandom_range(int'(lit), 1);
      dark = lit - SB'(k);
    end else if (mode < 7) begin
      dark = SB'($urandom_range(SAMPLE_FULL));
    end else if (mode == 7) begin
      dark = lit;
    end else begin
      lit  = edge_code();
      dark = edge_code();
    end
  endfunction

  // one scan transfer; the model runs at the accepting edge
  task automatic send_scan(input scan_t s);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      scan.valid <= 1'b0;
      @(negedge clk);
    end
    scan.valid          <= 1'b1;
    scan.battery_sample <= s.battery;
    scan.sample_a       <= s.smp[0];
    scan.sample_b       <= s.smp[1];
    scan.sample_c       <= s.smp[2];
    scan.sample_d       <= s.smp[3];
    do @(posedge clk); while (!scan.ready);
    pending_readings.push_back(predict_reading(s));
  endtask

  // four scans: emitter two, lit low half, lit high half, dark
  task automatic send_frame(input logic [SB-1:0] battery, input chan_t lit, input chan_t dark);
    scan_t s;
    for (int p = 0; p < 4; p++) begin
      s.battery = battery;
      for (int ch = 0; ch < LARS_CHANNELS; ch++) s.smp[ch] = pick_code();
      case (phase_t'(p))
        PH_LIT_LO: for (int ch = 0; ch < LARS_LO_CHANNELS; ch++) s.smp[ch] = lit[ch];
        PH_LIT_HI: for (int ch = LARS_LO_CHANNELS; ch < LARS_CHANNELS; ch++) s.smp[ch] = lit[ch];
        PH_DARK:   s.smp = dark;
        default:   ;
      endcase
      send_scan(s);
    end
  endtask

  // largest and smallest accepted differences, full-scale lit minus one
  task automatic test_level_limits();
    send_frame(SB'(SAMPLE_FULL), chans(4094, 1, 2048, 4095), chans(0, 0, 1024, 1));
    send_frame('0, chans(1, 4094, 4094, 1), chans(0, 0, 1, 0));
  endtask

  // zero, negative and full-scale differences hold the level; in-range ones between them update it
  task automatic test_out_of_range();
    send_frame('0, chans(4095, 0, 2000, 0), chans(0, 4095, 2000, 1));
    send_frame(SB'(SAMPLE_FULL), chans(2, 4095, 4095, 4095), chans(1, 1, 0, 4094));
    send_frame(SB'(SAMPLE_FULL), chans(4095, 4095, 4095, 4095), chans(4095, 4095, 4095, 4095));
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int frames);
    chan_t lit;
    chan_t dark;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int f = 0; f < frames; f++) begin
      for (int ch = 0; ch < LARS_CHANNELS; ch++) pick_pair(lit[ch], dark[ch]);
      send_frame(pick_code(), lit, dark);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    reading_t act;
    reading_t exp_r;
    if (!rst && result.valid && result.ready) begin
      act.emit_one   = result.emitter_one;
      act.emit_two   = result.emitter_two;
      act.frame_done = result.frame_done;
      act.battery    = result.battery_code;
      act.level      = {result.level_d, result.level_c, result.level_b, result.level_a};
      act.change     = {result.change_d, result.change_c, result.change_b, result.change_a};
      if (pending_readings.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= SHOW_LIMIT)
          $display("unexpected result transfer: %s", reading_str(act));
      end else begin
        exp_r = pending_readings.pop_front();
        if (act !== exp_r) begin
          fault_cnt++;
          if (fault_cnt <= SHOW_LIMIT) begin
            $display("mismatch expected: %s", reading_str(exp_r));
            $display("         actual:   %s", reading_str(act));
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    scan.valid          = 1'b0;
    scan.battery_sample = '0;
    scan.sample_a       = '0;
    scan.sample_b       = '0;
    scan.sample_c       = '0;
    scan.sample_d       = '0;
    result.ready        = 1'b0;
    src_idle_pct        = 29;
    snk_idle_pct        = 77;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_level_limits();
    test_out_of_range();
    test_random_traffic(29, 77, 38);
    test_random_traffic(77, 29, 38);
    test_random_traffic(0, 0, 37);

    @(negedge clk);
    scan.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
